### rtl/opw_pkg.sv
package opw_pkg;

    localparam int MAX_BINS_DEF = 256;
    localparam int MAX_RADIUS_DEF = 7;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = 24;
    localparam int COUNT_W = 8;
    localparam int LUMA_W = 34;
    localparam logic [15:0] W_RED = 16'd19661;
    localparam logic [15:0] W_GREEN = 16'd38666;
    localparam logic [15:0] W_BLUE = 16'd7209;
    localparam logic [7:0] COUNT_LIMIT = 8'd255;
    localparam logic [7:0] LEVEL_RESET = 8'd30;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEEP_SAMPLES = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic [7:0]          bin;
        logic                add;
        logic                last;
        logic [SAMPLE_W-1:0] alpha;
    } work_t;

endpackage

### rtl/opw_front.sv
module opw_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          red,
    input  logic [15:0]          green,
    input  logic [15:0]          blue,
    input  logic                 in_image,
    input  logic                 is_last,
    input  logic [15:0]          center_alpha,
    input  logic [7:0]           levels,
    input  logic                 deep,
    output logic                 wk_valid,
    input  logic                 wk_ready,
    output opw_pkg::work_t       wk
);

    localparam logic [42:0] DEN_DEEP    = 43'hFFFF << 16;
    localparam logic [42:0] DEN_SHALLOW = 43'hFF << 16;

    // Stage one forms the luma; stage two quantizes it to a bin.
    logic                 s1_valid_reg;
    logic [15:0]          s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;
    logic                 s1_add_reg, s1_last_reg;
    logic [33:0]          s1_luma_reg;
    logic                 s2_valid_reg;
    opw_pkg::work_t       s2_reg;
    logic [15:0]          mr, mg, mb;
    logic                 adv2, adv1;

    assign mr = deep ? red : {8'd0, red[7:0]};
    assign mg = deep ? green : {8'd0, green[7:0]};
    assign mb = deep ? blue : {8'd0, blue[7:0]};

    assign adv2 = !s2_valid_reg || wk_ready;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    logic [7:0] bin_c;
    always_comb
    begin
        logic [42:0] t;
        logic [42:0] a;
        logic [42:0] quo;
        // The quotient never exceeds 255, so the reciprocal forms below are exact.
        t = {8'd0, s1_luma_reg, 1'b0} * {35'd0, levels} + (deep ? DEN_DEEP : DEN_SHALLOW);
        a = t >> 17;
        if (deep)
            quo = (a + (a >> 16) + 43'd1) >> 16;
        else
            quo = (a + (a >> 8) + 43'd1) >> 8;
        if (quo > {35'd0, levels})
            bin_c = levels;
        else
            bin_c = quo[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_r_reg    <= mr;
            s1_g_reg    <= mg;
            s1_b_reg    <= mb;
            s1_a_reg    <= center_alpha;
            s1_add_reg  <= in_image;
            s1_last_reg <= is_last;
            s1_luma_reg <= {18'd0, mr} * opw_pkg::W_RED + {18'd0, mg} * opw_pkg::W_GREEN
                         + {18'd0, mb} * opw_pkg::W_BLUE;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_reg.red   <= s1_r_reg;
            s2_reg.green <= s1_g_reg;
            s2_reg.blue  <= s1_b_reg;
            s2_reg.alpha <= s1_a_reg;
            s2_reg.add   <= s1_add_reg;
            s2_reg.last  <= s1_last_reg;
            s2_reg.bin   <= bin_c;
        end
    end

    assign wk_valid = s2_valid_reg;
    assign wk = s2_reg;

endmodule

### rtl/opw_back.sv
module opw_back
#(
    parameter int MAX_BINS = opw_pkg::MAX_BINS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wk_valid,
    output logic           wk_ready,
    input  opw_pkg::work_t wk,
    input  logic [7:0]     levels,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [15:0]    res_red,
    output logic [15:0]    res_green,
    output logic [15:0]    res_blue,
    output logic [15:0]    res_alpha
);

    localparam int BW = $clog2(MAX_BINS);

    typedef enum logic [5:0] {
        ST_ACC  = 6'b000001,
        ST_RD   = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_OUT  = 6'b010000,
        ST_CLR  = 6'b100000
    } state_t;

    state_t state_reg;
    logic [7:0]  cnt_mem [MAX_BINS];
    logic [71:0] sum_mem [MAX_BINS];
    logic [BW:0] idx_reg;
    logic [7:0]  best_cnt_reg;
    logic [7:0]  rd_cnt_reg;
    logic [71:0] rd_sum_reg;
    logic [BW:0] rd_idx_reg;
    logic [15:0] alpha_reg;
    logic [23:0] rem_reg [3];
    logic [15:0] quo_reg [3];
    logic [4:0]  step_reg;
    logic [BW-1:0] bin_ix;
    logic [BW:0] lev_eff;
    logic [71:0] pend_sum_reg;

    assign lev_eff = ({1'b0, levels} > 9'(MAX_BINS - 1)) ? (BW+1)'(MAX_BINS - 1)
                   : (BW+1)'(levels);
    assign bin_ix = (wk.bin > 8'(lev_eff)) ? BW'(lev_eff) : BW'(wk.bin);

    // Accumulation reads then writes the bin memory; each beat is held through its read and taken with its write.
    logic acc_phase_reg;
    logic [7:0]  c_rd_reg;
    logic [71:0] s_rd_reg;
    assign wk_ready = (state_reg == ST_ACC) && acc_phase_reg;

    logic [23:0] div_sub [3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            div_sub[k] = {rem_reg[k][22:0], quo_reg[k][15]} - {16'd0, best_cnt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            idx_reg       <= '0;
            acc_phase_reg <= 1'b0;
            res_valid     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_ACC:
                begin
                    if (wk_valid)
                        acc_phase_reg <= !acc_phase_reg;
                    if (wk_valid && acc_phase_reg && wk.last)
                    begin
                        state_reg <= ST_RD;
                        idx_reg   <= '0;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_SCAN;
                    idx_reg   <= idx_reg + 1'b1;
                end
                ST_SCAN:
                begin
                    if (rd_idx_reg >= lev_eff)
                    begin
                        state_reg <= ST_DIV;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DIV:
                begin
                    if (step_reg == 5'd16 || best_cnt_reg == 8'd0)
                    begin
                        state_reg <= ST_OUT;
                        res_valid <= 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (res_ready)
                    begin
                        res_valid <= 1'b0;
                        state_reg <= ST_CLR;
                        idx_reg   <= '0;
                    end
                end
                ST_CLR:
                begin
                    if (idx_reg == (BW+1)'(MAX_BINS - 1))
                    begin
                        state_reg     <= ST_ACC;
                        acc_phase_reg <= 1'b0;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                default: state_reg <= ST_CLR;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cnt_reg <= cnt_mem[idx_reg[BW-1:0]];
        rd_sum_reg <= sum_mem[idx_reg[BW-1:0]];
        rd_idx_reg <= idx_reg;
        c_rd_reg   <= cnt_mem[bin_ix];
        s_rd_reg   <= sum_mem[bin_ix];
        if (state_reg == ST_CLR)
        begin
            cnt_mem[idx_reg[BW-1:0]] <= '0;
            sum_mem[idx_reg[BW-1:0]] <= '0;
        end
        else if (state_reg == ST_ACC && wk_valid && acc_phase_reg && wk.add
                 && c_rd_reg != opw_pkg::COUNT_LIMIT)
        begin
            cnt_mem[bin_ix] <= c_rd_reg + 8'd1;
            sum_mem[bin_ix] <= {s_rd_reg[71:48] + {8'd0, wk.red},
                                s_rd_reg[47:24] + {8'd0, wk.green},
                                s_rd_reg[23:0] + {8'd0, wk.blue}};
        end
        if (state_reg == ST_ACC && wk_valid && acc_phase_reg)
            alpha_reg <= wk.alpha;
        if (state_reg == ST_RD)
            best_cnt_reg <= '0;
        if (state_reg == ST_SCAN && rd_cnt_reg > best_cnt_reg)
        begin
            best_cnt_reg <= rd_cnt_reg;
            pend_sum_reg <= rd_sum_reg;
        end
        if (state_reg == ST_SCAN)
            step_reg <= '0;
        if (state_reg == ST_SCAN && rd_idx_reg >= lev_eff)
        begin
            if (rd_cnt_reg > best_cnt_reg)
            begin
                quo_reg[0] <= 16'(rd_sum_reg[71:48]);
                quo_reg[1] <= 16'(rd_sum_reg[47:24]);
                quo_reg[2] <= 16'(rd_sum_reg[23:0]);
                rem_reg[0] <= {16'd0, rd_sum_reg[71:64]};
                rem_reg[1] <= {16'd0, rd_sum_reg[47:40]};
                rem_reg[2] <= {16'd0, rd_sum_reg[23:16]};
            end
            else
            begin
                quo_reg[0] <= 16'(pend_sum_reg[71:48]);
                quo_reg[1] <= 16'(pend_sum_reg[47:24]);
                quo_reg[2] <= 16'(pend_sum_reg[23:0]);
                rem_reg[0] <= {16'd0, pend_sum_reg[71:64]};
                rem_reg[1] <= {16'd0, pend_sum_reg[47:40]};
                rem_reg[2] <= {16'd0, pend_sum_reg[23:16]};
            end
        end
        if (state_reg == ST_DIV && step_reg != 5'd16)
        begin
            step_reg <= step_reg + 5'd1;
            for (int k = 0; k < 3; k++)
            begin
                if (!div_sub[k][23])
                begin
                    rem_reg[k] <= div_sub[k];
                    quo_reg[k] <= {quo_reg[k][14:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_reg[k][22:0], quo_reg[k][15]};
                    quo_reg[k] <= {quo_reg[k][14:0], 1'b0};
                end
            end
        end
    end

    assign res_red   = (best_cnt_reg == 8'd0) ? 16'd0 : quo_reg[0];
    assign res_green = (best_cnt_reg == 8'd0) ? 16'd0 : quo_reg[1];
    assign res_blue  = (best_cnt_reg == 8'd0) ? 16'd0 : quo_reg[2];
    assign res_alpha = alpha_reg;

endmodule

### rtl/oil_paint_window_mode.sv
// Oil-paint window mode: push the pixels of one window on the input queue
// (push/full); the result of a window appears on the output queue
// (empty/pop) after the pixel marked is_last.
// A front part forms luma and the bin in two register stages; the back part
// updates the bin store with a registered read then a write, so it takes a
// new pixel only after the write for the one before.
// After the last pixel is accepted it passes the two front stages and the
// store's read then write; the scan then reads L+1 bins one a cycle, with L
// the effective level count, and a restoring divide forms the three channel
// means before empty falls. A window with no pixel inside the image skips
// the divide. The result is held until popped.
// After the pop, and after reset, a clearing pass over all bins empties
// the store. While the back part is busy or stalled by the receiver the front
// still takes up to two pixels, then holds full high.
// Configuration writes take effect at once and belong between windows.
module oil_paint_window_mode
#(
    parameter int MAX_BINS = opw_pkg::MAX_BINS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic        in_image,
    input  logic        is_last,
    input  logic [15:0] center_alpha,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] out_red,
    output logic [15:0] out_green,
    output logic [15:0] out_blue,
    output logic [15:0] out_alpha,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]     level_count_reg;
    logic           deep_samples_reg;
    logic           in_ready;
    logic           wk_valid;
    logic           wk_ready;
    opw_pkg::work_t wk;
    logic           res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg  <= opw_pkg::LEVEL_RESET;
            deep_samples_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == opw_pkg::REG_LEVEL_COUNT)
                level_count_reg <= cfg_data;
            else if (cfg_index == opw_pkg::REG_DEEP_SAMPLES)
                deep_samples_reg <= cfg_data[0];
        end
    end

    opw_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue), .in_image(in_image),
        .is_last(is_last), .center_alpha(center_alpha),
        .levels(level_count_reg), .deep(deep_samples_reg),
        .wk_valid(wk_valid), .wk_ready(wk_ready), .wk(wk)
    );

    opw_back #(.MAX_BINS(MAX_BINS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .wk_valid(wk_valid), .wk_ready(wk_ready),
        .wk(wk), .levels(level_count_reg), .res_valid(res_valid),
        .res_ready(pop), .res_red(out_red), .res_green(out_green),
        .res_blue(out_blue), .res_alpha(out_alpha)
    );

    assign full  = !in_ready;
    assign empty = !res_valid;

endmodule

### rtl/opw_checker.sv
module opw_sva
(
    input logic clk,
    input logic rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic [15:0] out_red
);

    a_res_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped before pop");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(out_red))
        else $error("result changed while waiting");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop |=> empty)
        else $error("result repeated");

    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("queue flags unknown");

endmodule

bind oil_paint_window_mode opw_sva u_chk
(
    .clk(clk), .rst_n(rst_n), .full(full),
    .empty(empty), .pop(pop), .out_red(out_red)
);

### dv/opw_checker.sv
module opw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic        in_image,
    input  logic        is_last,
    input  logic [15:0] center_alpha,
    input  logic        empty,
    input  logic        pop,
    input  logic [15:0] out_red,
    input  logic [15:0] out_green,
    input  logic [15:0] out_blue,
    input  logic [15:0] out_alpha,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    output int          pending,
    output int          failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [15:0] a;
    } colour_t;

    logic [7:0]  levels;
    logic        deep;
    logic [7:0]  hist_count [opw_pkg::MAX_BINS_DEF];
    logic [23:0] hist_red   [opw_pkg::MAX_BINS_DEF];
    logic [23:0] hist_green [opw_pkg::MAX_BINS_DEF];
    logic [23:0] hist_blue  [opw_pkg::MAX_BINS_DEF];
    colour_t     mode_colours [$];

    function automatic logic [7:0] luma_bin(input logic [15:0] r, input logic [15:0] g,
                                            input logic [15:0] b);
        logic [63:0] luma;
        logic [63:0] den;
        logic [63:0] bin;
        den = deep ? 64'd65535 << 16 : 64'd255 << 16;
        luma = 64'(opw_pkg::W_RED) * r + 64'(opw_pkg::W_GREEN) * g
             + 64'(opw_pkg::W_BLUE) * b;
        bin = (64'd2 * luma * levels + den) / (64'd2 * den);
        if (bin > levels)
            bin = levels;
        return bin[7:0];
    endfunction

    task automatic clear_hist();
        for (int i = 0; i < opw_pkg::MAX_BINS_DEF; i++)
        begin
            hist_count[i] = '0;
            hist_red[i] = '0;
            hist_green[i] = '0;
            hist_blue[i] = '0;
        end
    endtask

    task automatic take_pixel();
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [7:0]  bin;
        logic [8:0]  best;
        logic [7:0]  best_count;
        colour_t     res;
        best = '0;
        best_count = '0;
        r = deep ? red : {8'd0, red[7:0]};
        g = deep ? green : {8'd0, green[7:0]};
        b = deep ? blue : {8'd0, blue[7:0]};
        if (in_image)
        begin
            bin = luma_bin(r, g, b);
            if (hist_count[bin] != opw_pkg::COUNT_LIMIT)
            begin
                hist_count[bin] = hist_count[bin] + 8'd1;
                hist_red[bin] = hist_red[bin] + r;
                hist_green[bin] = hist_green[bin] + g;
                hist_blue[bin] = hist_blue[bin] + b;
            end
        end
        if (is_last)
        begin
            for (int i = 0; i <= levels; i++)
            begin
                if (hist_count[i] > best_count)
                begin
                    best_count = hist_count[i];
                    best = 9'(i);
                end
            end
            res.a = center_alpha;
            if (best_count == 0)
            begin
                res.r = '0;
                res.g = '0;
                res.b = '0;
            end
            else
            begin
                res.r = 16'(hist_red[best] / best_count);
                res.g = 16'(hist_green[best] / best_count);
                res.b = 16'(hist_blue[best] / best_count);
            end
            mode_colours.push_back(res);
            clear_hist();
        end
    endtask

    task automatic compare_beat();
        colour_t want;
        if (mode_colours.size() == 0)
        begin
            $error("result beat with nothing expected");
            failures++;
        end
        else
        begin
            want = mode_colours.pop_front();
            if (out_red !== want.r)
            begin
                $error("out_red expected %0d actual %0d", want.r, out_red);
                failures++;
            end
            if (out_green !== want.g)
            begin
                $error("out_green expected %0d actual %0d", want.g, out_green);
                failures++;
            end
            if (out_blue !== want.b)
            begin
                $error("out_blue expected %0d actual %0d", want.b, out_blue);
                failures++;
            end
            if (out_alpha !== want.a)
            begin
                $error("out_alpha expected %0d actual %0d", want.a, out_alpha);
                failures++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels <= opw_pkg::LEVEL_RESET;
            deep <= 1'b0;
            clear_hist();
            mode_colours.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == opw_pkg::REG_LEVEL_COUNT)
                    levels <= cfg_data;
                else if (cfg_index == opw_pkg::REG_DEEP_SAMPLES)
                    deep <= cfg_data[0];
            end
            if (pop && !empty)
                compare_beat();
            if (push && !full)
                take_pixel();
            pending = mode_colours.size();
        end
    end
endmodule

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] red = '0;
    logic [15:0] green = '0;
    logic [15:0] blue = '0;
    logic        in_image = 1'b0;
    logic        is_last = 1'b0;
    logic [15:0] center_alpha = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    int          pending;
    int          failures;
    int          burst_left = 0;
    int          quiet_cycles = 0;
    logic [15:0] palette [4];
    int          lev_set [7] = '{30, 1, 255, 0, 255, 7, 100};
    int          deep_set [7] = '{0, 0, 0, 0, 1, 1, 1};

    always #5 clk = ~clk;

    oil_paint_window_mode uut (.*);

    opw_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // The receiver switches between free flow, random stalls and long stalls.
    always @(negedge clk)
    begin
        int mode;
        mode = int'(($time / 640) % 3);
        if (mode == 0)
            pop <= 1'b1;
        else if (mode == 1)
            pop <= 1'($urandom_range(0, 1));
        else
            pop <= ($urandom_range(0, 7) == 0);
    end

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b, input logic visible,
                              input logic last, input logic [15:0] alpha);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        push <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        in_image <= visible;
        is_last <= last;
        center_alpha <= alpha;
        do
            @(posedge clk);
        while (full);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_window(input int length);
        logic        clustered;
        logic        outside;
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        int          k;
        clustered = ($urandom_range(0, 9) < 5);
        outside = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < 4; i++)
            palette[i] = 16'($urandom);
        for (int i = 0; i < length; i++)
        begin
            if (clustered)
            begin
                k = $urandom_range(0, 3);
                r = palette[k];
                g = palette[(k + 1) % 4];
                b = palette[(k + 2) % 4];
            end
            else
            begin
                r = 16'($urandom);
                g = 16'($urandom);
                b = 16'($urandom);
            end
            send_pixel(r, g, b, !outside && ($urandom_range(0, 9) != 0),
                       i == length - 1, 16'($urandom));
        end
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Directed windows at the reset settings.
        send_pixel('0, '0, '0, 1'b1, 1'b1, '0);
        send_pixel('1, '1, '1, 1'b1, 1'b1, '1);
        send_pixel(16'h1234, 16'h5678, 16'h9abc, 1'b0, 1'b0, '0);
        send_pixel(16'h0f0f, 16'hf0f0, 16'h00ff, 1'b0, 1'b1, 16'hffff);
        send_pixel(16'h00ff, 16'h00ff, 16'h00ff, 1'b1, 1'b0, '0);
        send_pixel(16'h0010, 16'h0010, 16'h0010, 1'b1, 1'b1, 16'h8001);
        send_pixel(16'hff20, 16'h0040, 16'h0080, 1'b1, 1'b0, '0);
        send_pixel(16'h0021, 16'h0043, 16'h0085, 1'b1, 1'b0, '0);
        send_pixel(16'h00c8, 16'h00c8, 16'h00c8, 1'b1, 1'b0, '0);
        send_pixel(16'h00ca, 16'h00c6, 16'h00c9, 1'b1, 1'b0, '0);
        send_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h7fff);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            write_reg(opw_pkg::REG_LEVEL_COUNT, 8'(lev_set[p]));
            write_reg(opw_pkg::REG_DEEP_SAMPLES, 8'(deep_set[p]));
            if (lev_set[p] == 0)
            begin
                // Enough identical pixels to fill one bin to its limit.
                for (int i = 0; i < 260; i++)
                    send_pixel(16'h00ff, 16'h00ff, 16'h00ff, 1'b1, i == 259, 16'h5a5a);
                drain();
            end
            sent = 0;
            while (sent < 150)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 225)
                                                  : $urandom_range(1, 20);
                random_window(len);
                sent += len;
            end
            drain();
        end

        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
rtl/opw_pkg.sv
rtl/opw_front.sv
rtl/opw_back.sv
rtl/oil_paint_window_mode.sv
rtl/opw_checker.sv
dv/opw_checker.sv
dv/tb_top.sv
